// ===== hw/rtl/wch_pkg.sv =====
// ----------------------------------------------------------------------------
// Word count hash table package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package wch_pkg;

  localparam int unsigned TableSlots   = 4096;
  localparam int unsigned VocabEntries = 1024;
  localparam int unsigned WordBytes    = 64;

  localparam int unsigned SlotW   = $clog2(TableSlots);
  localparam int unsigned EntryW  = $clog2(VocabEntries);
  localparam int unsigned UsedW   = EntryW + 1;
  localparam int unsigned OfsW    = $clog2(WordBytes);
  localparam int unsigned LenW    = OfsW + 1;
  localparam int unsigned StoreAw = EntryW + OfsW;
  localparam int unsigned ProbeW  = SlotW + 1;
  localparam int unsigned CountW  = 31;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned StatusW = 3;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [LenW-1:0]   LenLimit = LenW'(WordBytes - 2);

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;

  typedef enum logic [StatusW-1:0] {
    ST_FOUND     = 3'd0,
    ST_ADDED     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EOS       = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OUT_WORD,
    OUT_EOS,
    OUT_LONG
  } out_sel_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_SLOT_CHK,
    S_LEN,
    S_CMP_RD,
    S_CMP,
    S_FOUND,
    S_COPY_RD,
    S_COPY_WR,
    S_INSERT,
    S_WORD_OUT,
    S_EOS_OUT,
    S_LONG_OUT
  } state_e;

  typedef struct packed {
    logic     in_ready;
    logic     clear_wr;
    logic     append;
    logic     probe_start;
    logic     probe_next;
    logic     ofs_clr;
    logic     ofs_inc;
    logic     copy_wr;
    logic     insert;
    logic     res_load;
    status_e  res_kind;
    logic     out_load;
    out_sel_e out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic in_valid;
    logic is_sep;
    logic is_nl;
    logic pend_zero;
    logic too_long;
    logic slot_valid;
    logic len_eq;
    logic byte_eq;
    logic ofs_last;
    logic last_probe;
    logic learn;
    logic vocab_full;
    logic out_free;
    logic nl_q;
  } dp_stat_t;

endpackage

// ===== hw/rtl/wch_if.sv =====
// ----------------------------------------------------------------------------
// Word count hash table channels
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface wch_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;

  modport source (output valid, output byte_value, input ready);
  modport sink (input valid, input byte_value, output ready);
endinterface

interface wch_res_if;
  logic                          valid;
  logic                          ready;
  logic [wch_pkg::IndexW-1:0]    word_index;
  logic [wch_pkg::StatusW-1:0]   status;
  logic [wch_pkg::CountW-1:0]    word_count;
  logic                          last;

  modport source (output valid, output word_index, output status, output word_count,
                  output last, input ready);
  modport sink (input valid, input word_index, input status, input word_count,
                input last, output ready);
endinterface

interface wch_cfg_if;
  logic valid;
  logic ready;
  logic learn_mode;

  modport source (output valid, output learn_mode, input ready);
  modport sink (input valid, input learn_mode, output ready);
endinterface

// ===== hw/rtl/wch_ctrl.sv =====
// ----------------------------------------------------------------------------
// Word count hash table controller
// Sequences slot clearing, byte intake, probing, compare, insert and output.
// ----------------------------------------------------------------------------
module wch_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wch_pkg::dp_stat_t   stat_i,
  output wch_pkg::ctrl_cmd_t  cmd_o
);

  wch_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wch_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wch_pkg::S_CLEAR: begin
        if (stat_i.clear_done) state_d = wch_pkg::S_IDLE;
      end
      wch_pkg::S_IDLE: begin
        if (stat_i.in_valid) begin
          if (stat_i.is_sep) begin
            if (!stat_i.pend_zero) state_d = wch_pkg::S_SLOT;
            else if (stat_i.is_nl) state_d = wch_pkg::S_EOS_OUT;
          end else if (stat_i.too_long) begin
            state_d = wch_pkg::S_LONG_OUT;
          end
        end
      end
      wch_pkg::S_SLOT: state_d = wch_pkg::S_SLOT_CHK;
      wch_pkg::S_SLOT_CHK: begin
        if (!stat_i.slot_valid) begin
          if (stat_i.learn && !stat_i.vocab_full) state_d = wch_pkg::S_COPY_RD;
          else state_d = wch_pkg::S_WORD_OUT;
        end else begin
          state_d = wch_pkg::S_LEN;
        end
      end
      wch_pkg::S_LEN: begin
        if (stat_i.len_eq) state_d = wch_pkg::S_CMP_RD;
        else if (stat_i.last_probe) state_d = wch_pkg::S_WORD_OUT;
        else state_d = wch_pkg::S_SLOT;
      end
      wch_pkg::S_CMP_RD: state_d = wch_pkg::S_CMP;
      wch_pkg::S_CMP: begin
        if (!stat_i.byte_eq) begin
          if (stat_i.last_probe) state_d = wch_pkg::S_WORD_OUT;
          else state_d = wch_pkg::S_SLOT;
        end else if (stat_i.ofs_last) begin
          state_d = wch_pkg::S_FOUND;
        end else begin
          state_d = wch_pkg::S_CMP_RD;
        end
      end
      wch_pkg::S_FOUND: state_d = wch_pkg::S_WORD_OUT;
      wch_pkg::S_COPY_RD: state_d = wch_pkg::S_COPY_WR;
      wch_pkg::S_COPY_WR: begin
        if (stat_i.ofs_last) state_d = wch_pkg::S_INSERT;
        else state_d = wch_pkg::S_COPY_RD;
      end
      wch_pkg::S_INSERT: state_d = wch_pkg::S_WORD_OUT;
      wch_pkg::S_WORD_OUT: begin
        if (stat_i.out_free) state_d = stat_i.nl_q ? wch_pkg::S_EOS_OUT : wch_pkg::S_IDLE;
      end
      wch_pkg::S_EOS_OUT, wch_pkg::S_LONG_OUT: begin
        if (stat_i.out_free) state_d = wch_pkg::S_IDLE;
      end
      default: state_d = wch_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_kind = wch_pkg::ST_FOUND;
    cmd_o.out_sel  = wch_pkg::OUT_WORD;
    unique case (state_q)
      wch_pkg::S_CLEAR: cmd_o.clear_wr = 1'b1;
      wch_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          if (stat_i.is_sep) cmd_o.probe_start = 1'b1;
          else if (!stat_i.too_long) cmd_o.append = 1'b1;
        end
      end
      wch_pkg::S_SLOT_CHK: begin
        cmd_o.ofs_clr = 1'b1;
        if (!stat_i.slot_valid) begin
          if (!stat_i.learn) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = wch_pkg::ST_NOT_FOUND;
          end else if (stat_i.vocab_full) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = wch_pkg::ST_FULL;
          end
        end
      end
      wch_pkg::S_LEN: begin
        if (!stat_i.len_eq) begin
          if (stat_i.last_probe) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = stat_i.learn ? wch_pkg::ST_FULL : wch_pkg::ST_NOT_FOUND;
          end else begin
            cmd_o.probe_next = 1'b1;
          end
        end
      end
      wch_pkg::S_CMP: begin
        cmd_o.ofs_inc = 1'b1;
        if (!stat_i.byte_eq) begin
          if (stat_i.last_probe) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = stat_i.learn ? wch_pkg::ST_FULL : wch_pkg::ST_NOT_FOUND;
          end else begin
            cmd_o.probe_next = 1'b1;
          end
        end
      end
      wch_pkg::S_FOUND: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = wch_pkg::ST_FOUND;
      end
      wch_pkg::S_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        cmd_o.ofs_inc = 1'b1;
      end
      wch_pkg::S_INSERT: begin
        cmd_o.insert   = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_kind = wch_pkg::ST_ADDED;
      end
      wch_pkg::S_WORD_OUT: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_sel  = wch_pkg::OUT_WORD;
      end
      wch_pkg::S_EOS_OUT: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_sel  = wch_pkg::OUT_EOS;
      end
      wch_pkg::S_LONG_OUT: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_sel  = wch_pkg::OUT_LONG;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/wch_dp.sv =====
// ----------------------------------------------------------------------------
// Word count hash table datapath
// Pending word, hash, slot/vocabulary memories, compare and result register.
// ----------------------------------------------------------------------------
module wch_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  wch_byte_if.sink           byte_i,
  wch_res_if.source          res_o,
  wch_cfg_if.sink            cfg_i,
  input  wch_pkg::ctrl_cmd_t cmd_i,
  output wch_pkg::dp_stat_t  stat_o
);

  // Slot entries hold a valid bit above the vocabulary index.
  logic [wch_pkg::EntryW:0]     slot_mem [wch_pkg::TableSlots];
  logic [wch_pkg::LenW-1:0]     len_mem [wch_pkg::VocabEntries];
  logic [wch_pkg::CountW-1:0]   cnt_mem [wch_pkg::VocabEntries];
  logic [7:0]                   store_mem [2**wch_pkg::StoreAw];
  logic [7:0]                   pend_mem [wch_pkg::WordBytes];

  logic [wch_pkg::EntryW:0]     slot_rd_q;
  logic [wch_pkg::LenW-1:0]     len_rd_q;
  logic [wch_pkg::CountW-1:0]   cnt_rd_q;
  logic [7:0]                   store_rd_q;
  logic [7:0]                   pend_rd_q;

  logic                         learn_q;
  logic [wch_pkg::LenW-1:0]     len_q;
  logic [wch_pkg::SlotW-1:0]    hash_q;
  logic                         nl_q;
  logic [wch_pkg::SlotW-1:0]    probe_q;
  logic [wch_pkg::ProbeW-1:0]   nprobe_q;
  logic [wch_pkg::OfsW-1:0]     ofs_q;
  logic [wch_pkg::UsedW-1:0]    used_q;

  logic [wch_pkg::IndexW-1:0]   res_idx_q;
  wch_pkg::status_e             res_st_q;
  logic [wch_pkg::CountW-1:0]   res_cnt_q;

  logic                         out_valid_q;
  logic [wch_pkg::IndexW-1:0]   out_idx_q;
  logic [wch_pkg::StatusW-1:0]  out_st_q;
  logic [wch_pkg::CountW-1:0]   out_cnt_q;
  logic                         out_last_q;

  logic [7:0]                   in_byte;
  logic [wch_pkg::EntryW-1:0]   entry;
  logic [wch_pkg::EntryW-1:0]   new_entry;
  logic [wch_pkg::CountW-1:0]   cnt_inc;
  logic [wch_pkg::SlotW-1:0]    hash_d;
  logic                         out_free;

  assign in_byte   = byte_i.byte_value;
  assign entry     = slot_rd_q[wch_pkg::EntryW-1:0];
  assign new_entry = used_q[wch_pkg::EntryW-1:0];
  assign cnt_inc   = (cnt_rd_q == wch_pkg::CountMax) ? cnt_rd_q : cnt_rd_q + 1'b1;
  assign out_free  = !out_valid_q || res_o.ready;

  // All hash bits select the slot, and the low bits depend on low bits alone.
  assign hash_d = hash_q + (hash_q << 8) + {{(wch_pkg::SlotW-8){in_byte[7]}}, in_byte};

  assign byte_i.ready = cmd_i.in_ready;
  assign cfg_i.ready  = 1'b1;

  always_comb begin
    stat_o.clear_done = &probe_q;
    stat_o.in_valid   = byte_i.valid;
    stat_o.is_nl      = (in_byte == wch_pkg::ChNewline);
    stat_o.is_sep     = (in_byte == wch_pkg::ChSpace) || (in_byte == wch_pkg::ChTab) ||
                        (in_byte == wch_pkg::ChNewline);
    stat_o.pend_zero  = (len_q == '0);
    stat_o.too_long   = (len_q >= wch_pkg::LenLimit);
    stat_o.slot_valid = slot_rd_q[wch_pkg::EntryW];
    stat_o.len_eq     = (len_rd_q == len_q);
    stat_o.byte_eq    = (store_rd_q == pend_rd_q);
    stat_o.ofs_last   = ({1'b0, ofs_q} + 1'b1 == len_q);
    stat_o.last_probe = (nprobe_q == wch_pkg::ProbeW'(wch_pkg::TableSlots - 1));
    stat_o.learn      = learn_q;
    stat_o.vocab_full = used_q[wch_pkg::EntryW];
    stat_o.out_free   = out_free;
    stat_o.nl_q       = nl_q;
  end

  // Memories: registered reads every cycle, single write port each.
  always_ff @(posedge clk_i) begin
    slot_rd_q  <= slot_mem[probe_q];
    len_rd_q   <= len_mem[entry];
    cnt_rd_q   <= cnt_mem[entry];
    store_rd_q <= store_mem[{entry, ofs_q}];
    pend_rd_q  <= pend_mem[ofs_q];
    if (cmd_i.clear_wr) slot_mem[probe_q] <= '0;
    else if (cmd_i.insert) slot_mem[probe_q] <= {1'b1, new_entry};
    if (cmd_i.insert) len_mem[new_entry] <= len_q;
    if (cmd_i.insert) cnt_mem[new_entry] <= wch_pkg::CountW'(1);
    else if (cmd_i.res_load && cmd_i.res_kind == wch_pkg::ST_FOUND && learn_q) begin
      cnt_mem[entry] <= cnt_inc;
    end
    if (cmd_i.copy_wr) store_mem[{new_entry, ofs_q}] <= pend_rd_q;
    if (cmd_i.append) pend_mem[len_q[wch_pkg::OfsW-1:0]] <= in_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_q  <= 1'b1;
      len_q    <= '0;
      hash_q   <= '0;
      nl_q     <= 1'b0;
      probe_q  <= '0;
      nprobe_q <= '0;
      ofs_q    <= '0;
      used_q   <= '0;
    end else begin
      if (cfg_i.valid) learn_q <= cfg_i.learn_mode;
      if (cmd_i.in_ready && byte_i.valid) nl_q <= stat_o.is_nl;
      if (cmd_i.append) begin
        len_q  <= len_q + 1'b1;
        hash_q <= hash_d;
      end else if (cmd_i.out_load && cmd_i.out_sel == wch_pkg::OUT_WORD) begin
        len_q  <= '0;
        hash_q <= '0;
      end
      if (cmd_i.clear_wr) begin
        probe_q <= probe_q + 1'b1;
      end else if (cmd_i.probe_start) begin
        probe_q  <= hash_q;
        nprobe_q <= '0;
      end else if (cmd_i.probe_next) begin
        probe_q  <= probe_q + 1'b1;
        nprobe_q <= nprobe_q + 1'b1;
      end
      if (cmd_i.ofs_clr) ofs_q <= '0;
      else if (cmd_i.ofs_inc) ofs_q <= ofs_q + 1'b1;
      if (cmd_i.insert) used_q <= used_q + 1'b1;
    end
  end

  // Result of the finished word, held until it moves to the output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_st_q <= cmd_i.res_kind;
      case (cmd_i.res_kind)
        wch_pkg::ST_FOUND: begin
          res_idx_q <= wch_pkg::IndexW'(entry);
          res_cnt_q <= learn_q ? cnt_inc : '0;
        end
        wch_pkg::ST_ADDED: begin
          res_idx_q <= wch_pkg::IndexW'(new_entry);
          res_cnt_q <= wch_pkg::CountW'(1);
        end
        default: begin
          res_idx_q <= '0;
          res_cnt_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_sel)
        wch_pkg::OUT_WORD: begin
          out_idx_q  <= res_idx_q;
          out_st_q   <= res_st_q;
          out_cnt_q  <= res_cnt_q;
          out_last_q <= !nl_q;
        end
        wch_pkg::OUT_EOS: begin
          out_idx_q  <= '0;
          out_st_q   <= wch_pkg::ST_EOS;
          out_cnt_q  <= '0;
          out_last_q <= 1'b1;
        end
        default: begin
          out_idx_q  <= '0;
          out_st_q   <= wch_pkg::ST_TOO_LONG;
          out_cnt_q  <= '0;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.word_index = out_idx_q;
  assign res_o.status     = out_st_q;
  assign res_o.word_count = out_cnt_q;
  assign res_o.last       = out_last_q;

endmodule

// ===== hw/rtl/word_count_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// Word count hash table unit
// Splits a byte stream into words and counts or looks them up in a
// linear-probing hash table.
//
//   Channel   Direction  Payload
//   byte_i    in         byte_value[7:0]
//   res_o     out        word_index[9:0], status[2:0], word_count[30:0], last
//   cfg_i     in         learn_mode
//
// A byte inside a word is appended in the idle state. A word end reads and
// checks a slot, then per probed slot checks the length and reads and compares
// each byte; an insert reads each byte of the pending word and writes it to the
// word store. After reset all 4096 slots are cleared; no byte is taken
// meanwhile. A stalled result register holds the controller in its output
// state when the next result is ready; bytes inside a word are still taken
// while an earlier result waits in that register.
// ----------------------------------------------------------------------------
module word_count_hash_table_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  wch_byte_if.sink  byte_i,
  wch_res_if.source res_o,
  wch_cfg_if.sink   cfg_i
);

  wch_pkg::ctrl_cmd_t cmd;
  wch_pkg::dp_stat_t  stat;

  wch_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  wch_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule
